// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and active-low reset.
`define GONM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication.
`define GONM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GONM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gonm_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle map package
// Field widths, operation codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gonm_pkg;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ID_W        = 12;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WORD_IDX_W  = 6;

  localparam int unsigned DEF_MAX_COLUMNS = 64;
  localparam int unsigned DEF_MAX_ROWS    = 64;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TOGGLE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] dividend;
  } div_req_t;

endpackage

// ===== hw/rtl/gonm_divider.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gonm_divider import gonm_pkg::*; #(
  parameter int unsigned DIVISOR_W = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIVISOR_W-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(ID_W + 1);

  logic [ID_W-1:0]      dvd_q, dvd_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_q, dvd_q[ID_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = divisor_i;
      rem_d = '0;
      cnt_d = CNT_W'(ID_W);
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[ID_W-2:0], 1'b0};
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

// ===== hw/rtl/grid_obstacle_map_neighbors_core.sv =====
// ----------------------------------------------------------------------------
// Grid obstacle map with 4-neighbour query
// Bit map in a single-port word memory, sequenced one operation at a time.
// ----------------------------------------------------------------------------
// One operation is taken when start_i is high and busy_o low; busy_o stays high
// until the result strobe, which lasts one cycle and cannot be held off. An id
// outside the grid reports from the check state; a toggle or remove reports as
// its word is written back, a query on a blocked cell once the cell is read, and
// a query on a free cell after the remainder unit has found the column one bit
// of the 12-bit id at a time and the in-grid neighbours have been read one after
// another through the single memory port. Clear-all sweeps the memory one 64-bit
// word per cycle and shows the result strobe as the sweep ends. The same sweep
// runs after reset with busy_o high; register writes are taken throughout.
`timescale 1ns / 1ps

module grid_obstacle_map_neighbors_core import gonm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [ID_W-1:0]      cell_id_i,
  output logic                 result_valid_o,
  output logic                 cell_valid_o,
  output logic                 cell_blocked_o,
  output logic [MASK_W-1:0]    neighbor_mask_o,
  output logic [COUNT_W-1:0]   neighbor_count_o
);

  localparam int unsigned WW     = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned HW     = $clog2(MAX_ROWS + 1);
  localparam int unsigned WCW    = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned HCW    = (HW > CFG_W) ? HW : CFG_W;
  localparam int unsigned CELLW  = WW + HW;
  localparam int unsigned NW     = ((CELLW > ID_W) ? CELLW : ID_W) + 1;
  localparam int unsigned MAP_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned DEPTH  = (MAP_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_CELL_DATA,
    ST_DIV_WAIT,
    ST_NB_ADDR,
    ST_NB_DATA
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     width_q, height_q;
  op_e                  op_q;
  logic [ID_W-1:0]      id_q;
  logic [WAW-1:0]       clr_addr_q;
  logic                 clr_report_q;
  logic [1:0]           nb_q;
  logic [WORD_IDX_W-1:0] nb_bit_q;
  logic [MASK_W-1:0]    mask_q;
  logic [WW-1:0]        x_q;
  logic                 res_valid_q, res_cell_valid_q, res_blocked_q;
  logic [MASK_W-1:0]    res_mask_q;
  logic [COUNT_W-1:0]   res_count_q;

  logic [WW-1:0]        w_eff, w_q;
  logic [HW-1:0]        h_eff;
  logic [CELLW-1:0]     cells_q;
  logic [WCW-1:0]       w_raw;
  logic [HCW-1:0]       h_raw;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [WAW-1:0]       mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [NW-1:0]        id_x, w_x, cells_x, nb_opnd, nb_id;
  logic                 nb_sub, nb_inb;
  logic [WW:0]          x_inc;
  logic [WAW-1:0]       cell_word;
  logic [WORD_IDX_W-1:0] cell_bit;
  logic                 cell_old, cell_new, id_in_grid;
  logic [WORD_BITS-1:0] word_new;
  logic [MASK_W-1:0]    mask_upd;
  logic [COUNT_W-1:0]   count_upd;

  div_req_t             div_req;
  logic                 div_done;
  logic [WW-1:0]        div_rem;

  // Clamp registers to the usable grid and form the cell count.
  assign w_raw = WCW'(width_q);
  assign h_raw = HCW'(height_q);

  always_comb begin
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WCW'(MAX_COLUMNS)) begin
      w_eff = WW'(MAX_COLUMNS);
    end else begin
      w_eff = w_raw[WW-1:0];
    end
    if (h_raw == '0) begin
      h_eff = HW'(1);
    end else if (h_raw > HCW'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = h_raw[HW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_eff;
    cells_q <= CELLW'(w_eff) * CELLW'(h_eff);
  end

  // Cell and neighbour addressing.
  assign id_x       = NW'(id_q);
  assign w_x        = NW'(w_q);
  assign cells_x    = NW'(cells_q);
  assign id_in_grid = id_x < cells_x;
  assign cell_word  = id_x[WORD_IDX_W +: WAW];
  assign cell_bit   = id_x[WORD_IDX_W-1:0];
  assign cell_old   = rdata_q[cell_bit];
  assign cell_new   = (op_q == OP_TOGGLE) ? ~cell_old : 1'b0;
  assign x_inc      = {1'b0, x_q} + (WW+1)'(1);

  always_comb begin
    word_new           = rdata_q;
    word_new[cell_bit] = cell_new;
  end

  always_comb begin
    nb_sub  = (nb_q == NB_UP) || (nb_q == NB_LEFT);
    nb_opnd = ((nb_q == NB_UP) || (nb_q == NB_DOWN)) ? w_x : NW'(1);
    nb_id   = nb_sub ? (id_x - nb_opnd) : (id_x + nb_opnd);
    case (nb_q)
      NB_UP:    nb_inb = id_x >= w_x;
      NB_DOWN:  nb_inb = nb_id < cells_x;
      NB_RIGHT: nb_inb = x_inc < {1'b0, w_q};
      NB_LEFT:  nb_inb = x_q != '0;
      default:  nb_inb = 1'b0;
    endcase
  end

  always_comb begin
    mask_upd = mask_q;
    if (state_q == ST_NB_DATA) begin
      mask_upd[nb_q] = ~rdata_q[nb_bit_q];
    end
    count_upd = COUNT_W'(mask_upd[0]) + COUNT_W'(mask_upd[1]) +
                COUNT_W'(mask_upd[2]) + COUNT_W'(mask_upd[3]);
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_word;
    mem_wdata = word_new;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_q;
        mem_wdata = '0;
      end
      ST_CHECK: begin
        mem_re = 1'b1;
      end
      ST_CELL_DATA: begin
        mem_we = (op_q == OP_TOGGLE) || (op_q == OP_REMOVE);
      end
      ST_NB_ADDR: begin
        mem_re   = nb_inb;
        mem_addr = nb_id[WORD_IDX_W +: WAW];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign div_req.start    = (state_q == ST_CELL_DATA) && (op_q == OP_QUERY) && !cell_old;
  assign div_req.dividend = id_q;

  gonm_divider #(
    .DIVISOR_W (WW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .divisor_i   (w_q),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      width_q          <= GRID_RESET;
      height_q         <= GRID_RESET;
      op_q             <= OP_TOGGLE;
      id_q             <= '0;
      clr_addr_q       <= '0;
      clr_report_q     <= 1'b0;
      nb_q             <= NB_UP;
      nb_bit_q         <= '0;
      mask_q           <= '0;
      x_q              <= '0;
      res_valid_q      <= 1'b0;
      res_cell_valid_q <= 1'b0;
      res_blocked_q    <= 1'b0;
      res_mask_q       <= '0;
      res_count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:  width_q  <= cfg_wdata_i;
          REG_GRID_HEIGHT: height_q <= cfg_wdata_i;
          default:         width_q  <= width_q;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == WAW'(DEPTH - 1)) begin
            clr_addr_q  <= '0;
            state_q     <= ST_IDLE;
            res_valid_q <= clr_report_q;
            if (clr_report_q) begin
              res_cell_valid_q <= 1'b1;
              res_blocked_q    <= 1'b0;
              res_mask_q       <= '0;
              res_count_q      <= '0;
            end
          end else begin
            clr_addr_q  <= clr_addr_q + WAW'(1);
            res_valid_q <= 1'b0;
          end
        end
        ST_IDLE: begin
          res_valid_q <= 1'b0;
          if (start_i) begin
            op_q <= op_e'(op_i);
            id_q <= cell_id_i;
            if (op_e'(op_i) == OP_CLEAR) begin
              clr_report_q <= 1'b1;
              clr_addr_q   <= '0;
              state_q      <= ST_CLEAR;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (id_in_grid) begin
            res_valid_q <= 1'b0;
            state_q     <= ST_CELL_DATA;
          end else begin
            res_valid_q      <= 1'b1;
            res_cell_valid_q <= 1'b0;
            res_blocked_q    <= 1'b0;
            res_mask_q       <= '0;
            res_count_q      <= '0;
            state_q          <= ST_IDLE;
          end
        end
        ST_CELL_DATA: begin
          if (op_q == OP_QUERY && !cell_old) begin
            res_valid_q <= 1'b0;
            state_q     <= ST_DIV_WAIT;
          end else begin
            res_valid_q      <= 1'b1;
            res_cell_valid_q <= 1'b1;
            res_blocked_q    <= (op_q == OP_QUERY) ? cell_old : cell_new;
            res_mask_q       <= '0;
            res_count_q      <= '0;
            state_q          <= ST_IDLE;
          end
        end
        ST_DIV_WAIT: begin
          res_valid_q <= 1'b0;
          if (div_done) begin
            x_q     <= div_rem;
            nb_q    <= NB_UP;
            mask_q  <= '0;
            state_q <= ST_NB_ADDR;
          end
        end
        ST_NB_ADDR: begin
          nb_bit_q <= nb_id[WORD_IDX_W-1:0];
          if (nb_inb) begin
            res_valid_q <= 1'b0;
            state_q     <= ST_NB_DATA;
          end else if (nb_q == NB_LEFT) begin
            res_valid_q      <= 1'b1;
            res_cell_valid_q <= 1'b1;
            res_blocked_q    <= 1'b0;
            res_mask_q       <= mask_upd;
            res_count_q      <= count_upd;
            state_q          <= ST_IDLE;
          end else begin
            res_valid_q <= 1'b0;
            nb_q        <= nb_q + 2'd1;
          end
        end
        ST_NB_DATA: begin
          mask_q <= mask_upd;
          if (nb_q == NB_LEFT) begin
            res_valid_q      <= 1'b1;
            res_cell_valid_q <= 1'b1;
            res_blocked_q    <= 1'b0;
            res_mask_q       <= mask_upd;
            res_count_q      <= count_upd;
            state_q          <= ST_IDLE;
          end else begin
            res_valid_q <= 1'b0;
            nb_q        <= nb_q + 2'd1;
            state_q     <= ST_NB_ADDR;
          end
        end
        default: begin
          res_valid_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = state_q != ST_IDLE;
  assign result_valid_o   = res_valid_q;
  assign cell_valid_o     = res_cell_valid_q;
  assign cell_blocked_o   = res_blocked_q;
  assign neighbor_mask_o  = res_mask_q;
  assign neighbor_count_o = res_count_q;

endmodule

// ===== hw/rtl/gonm_checker.sv =====
// ----------------------------------------------------------------------------
// Obstacle map port checker
// Port-level properties of the operation and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gonm_checker import gonm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input logic               cell_valid_o,
  input logic               cell_blocked_o,
  input logic [MASK_W-1:0]  neighbor_mask_o,
  input logic [COUNT_W-1:0] neighbor_count_o
);

  `GONM_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accepted beat did not raise busy")
  `GONM_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o, "result strobe longer than one cycle")
  `GONM_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy_o, "result shown while still busy")
  `GONM_ASSERT_IMP(a_count_match, clk_i, rst_ni, result_valid_o, neighbor_count_o == COUNT_W'($countones(neighbor_mask_o)), "neighbour count disagrees with mask")
  `GONM_ASSERT(a_invalid_empty, clk_i, rst_ni, !(result_valid_o && !cell_valid_o) || (!cell_blocked_o && neighbor_mask_o == '0), "invalid cell with non-empty result")

endmodule

bind grid_obstacle_map_neighbors_core gonm_checker u_checker (.*);
